### hdl/encoder_pid_motor_loop_macros.svh
// Assertion macros used by the encoder PID loop top level.
`ifndef ENCODER_PID_MOTOR_LOOP_MACROS_SVH
`define ENCODER_PID_MOTOR_LOOP_MACROS_SVH
`define EPML_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define EPML_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### hdl/epml_pkg.sv
// Package with shared types and constants of the encoder PID loop.
`default_nettype none
package epml_pkg;
  localparam int unsigned NumRegs = 8;
  typedef enum logic [2:0] {
    RegMode    = 3'd0,
    RegKp      = 3'd1,
    RegKi      = 3'd2,
    RegKd      = 3'd3,
    RegSet     = 3'd4,
    RegFloor   = 3'd5,
    RegCeil    = 3'd6,
    RegPoll    = 3'd7
  } reg_idx_e;
  typedef enum logic [1:0] {
    ModeOff = 2'd0,
    ModePos = 2'd1,
    ModeVel = 2'd2,
    ModeRsv = 2'd3
  } mode_e;
  typedef enum logic [1:0] {
    DirStop = 2'd0,
    DirFwd  = 2'd1,
    DirBack = 2'd2,
    DirRsv  = 2'd3
  } dir_e;
  typedef enum logic [3:0] {
    StIdle, StVelDiv, StAccDiv, StErr, StDerDiv, StMulP, StMulI, StMulD, StScale, StOut
  } state_e;
  typedef struct packed {
    logic start;
    logic is_signed_neg;
  } div_ctrl_t;
endpackage
`default_nettype wire

### hdl/epml_div.sv
// Radix-2 restoring divider for a 64-bit magnitude by a 32-bit divisor.
`default_nettype none
module epml_div
  import epml_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire div_ctrl_t   ctrl_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic [63:0]      quotient_o
);
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [32:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    trial = '0;
    if (ctrl_i.start) begin
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = 7'd64;
      neg_d = ctrl_i.is_signed_neg;
    end else if (cnt_q != 7'd0) begin
      trial = {rem_q[31:0], quo_q[63]};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      neg_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = (cnt_q != 7'd0) || ctrl_i.start;
  assign quotient_o = neg_q ? (64'd0 - quo_q) : quo_q;
endmodule
`default_nettype wire

### hdl/epml_mul.sv
// Shift-and-add multiplier of a 64-bit signed value by a 32-bit signed value.
`default_nettype none
module epml_mul
  import epml_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [63:0]  a_i,
  input  wire logic [31:0]  b_i,
  output logic              busy_o,
  output logic [127:0]      prod_o
);
  logic [127:0] acc_q, acc_d;
  logic [127:0] mc_q, mc_d;
  logic [31:0]  mp_q, mp_d;
  logic [5:0]   cnt_q, cnt_d;

  always_comb begin
    acc_d = acc_q;
    mc_d  = mc_q;
    mp_d  = mp_q;
    cnt_d = cnt_q;
    if (start_i) begin
      acc_d = '0;
      mc_d  = {{64{a_i[63]}}, a_i};
      mp_d  = b_i;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      if (mp_q[0]) begin
        if (cnt_q == 6'd1) acc_d = acc_q - mc_q;
        else acc_d = acc_q + mc_q;
      end
      mc_d  = {mc_q[126:0], 1'b0};
      mp_d  = {mp_q[31], mp_q[31:1]};
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign busy_o = (cnt_q != 6'd0) || start_i;
  assign prod_o = acc_q;
endmodule
`default_nettype wire

### hdl/encoder_pid_motor_loop.sv
// Top level: encoder velocity sampling and position/velocity PID motor loop.
// A non-sampling input is answered from idle; a sampling one runs velocity and accel
// divides, then when active the PID steps (64-step divides, 32-step multiplies).
// Throughput: one request at a time; the next is taken once the result is taken.
// Reset: asynchronous active low; all but cnt_q, now_q, dt_q, sum_q reset; state to zero.
`default_nettype none
module encoder_pid_motor_loop
  import epml_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned INTEG_WIDTH = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // encoder_count [31:0], time_ms [63:32]
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // effort [8:0], direction [10:9], position_out [42:11], velocity_out [74:43],
  // accel_out [106:75], zero fill [111:107]
  output logic [111:0]     m_axis_tdata,
  // sampled [0]
  output logic             m_axis_tuser,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  `include "encoder_pid_motor_loop_macros.svh"

  localparam logic signed [63:0] IMax = (64'sd1 <<< (INTEG_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] IMin = -IMax - 64'sd1;
  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  mode_e             mode_q;
  logic signed [31:0] kp_q, ki_q, kd_q, set_q;
  logic [7:0]        floor_q, ceil_q;
  logic [15:0]       poll_q;

  logic signed [31:0] spos_q, svel_q, vel_q, acc_q, perr_q, cnt_q, err_q;
  logic [31:0]       stime_q, now_q, dt_q;
  logic signed [63:0] integ_q, der_q;
  logic signed [8:0]  eff_q;
  logic [127:0]      sum_q;
  logic              smp_q;
  state_e            st_q, st_d;

  logic              acc_in, pid_clear;
  logic [31:0]       elapsed, poll_eff;
  logic              active;

  logic              dneg;
  div_ctrl_t         dctrl_w;
  logic [63:0]       dnd, dquo;
  logic              dbusy, mstart, mbusy;
  logic [63:0]       ma;
  logic [31:0]       mb;
  logic [127:0]      mprod;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32Max) return 32'sh7fffffff;
    if (v < S32Min) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] absv(input logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  assign s_axis_tready = (st_q == StIdle) && !m_axis_tvalid;
  assign cfg_ready_o   = (st_q == StIdle);
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign pid_clear     = cfg_valid_i && cfg_ready_o && (cfg_index_i <= RegSet);
  assign poll_eff      = (poll_q == 16'd0) ? 32'd1 : {16'd0, poll_q};
  assign elapsed       = s_axis_tdata[63:32] - stime_q;
  assign active        = (mode_q == ModePos) || (mode_q == ModeVel);

  epml_div u_div (
    .clk_i, .rst_ni, .ctrl_i(dctrl_w), .dividend_i(dnd), .divisor_i(dt_q),
    .busy_o(dbusy), .quotient_o(dquo)
  );
  epml_mul u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb),
    .busy_o(mbusy), .prod_o(mprod)
  );

  logic signed [63:0] vnum, anum, dnum, pprod, isum, rawq, mag;
  logic [127:0]       sabs;
  logic signed [31:0] err_n;
  logic signed [32:0] dt_s;
  logic               upd_eff;
  logic signed [8:0]  eff_n;

  always_comb begin
    st_d   = st_q;
    dneg   = 1'b0;
    ma     = '0;
    mb     = '0;
    vnum   = (64'(signed'(cnt_q)) - 64'(signed'(spos_q))) <<< FRAC_BITS;
    anum   = 64'(signed'(vel_q)) - 64'(signed'(svel_q));
    dnum   = 64'(signed'(err_q)) - 64'(signed'(perr_q));
    unique case (st_q)
      StIdle: if (acc_in && elapsed >= poll_eff) st_d = StVelDiv;
      StVelDiv: begin
        if (!dbusy) st_d = StAccDiv;
      end
      StAccDiv: if (!dbusy) st_d = active ? StErr : StOut;
      StErr:    st_d = StDerDiv;
      StDerDiv: if (!dbusy) st_d = StMulP;
      StMulP:   if (!mbusy) st_d = StMulI;
      StMulI:   if (!mbusy) st_d = StMulD;
      StMulD:   if (!mbusy) st_d = StScale;
      StScale:  if (!mbusy) st_d = StOut;
      StOut:    st_d = StIdle;
      default:  st_d = StIdle;
    endcase
    dnd = absv(vnum);
    if (st_q == StVelDiv) dneg = vnum[63];
    if (st_q == StAccDiv) begin
      dnd  = absv(anum);
      dneg = anum[63];
    end
    if (st_q == StDerDiv) begin
      dnd  = absv(dnum);
      dneg = dnum[63];
    end
    if (st_q == StMulP) begin ma = 64'(signed'(err_q)); mb = kp_q; end
    if (st_q == StMulI) begin ma = integ_q; mb = ki_q; end
    if (st_q == StMulD) begin ma = der_q; mb = kd_q; end
  end

  // Divider and multiplier launches are one-shot on state entry.
  state_e st_prev_q;
  logic   entered;
  assign entered = st_q != st_prev_q;
  logic dstart_w, mstart_w;
  assign dstart_w = entered && (st_q == StVelDiv || st_q == StAccDiv || st_q == StDerDiv);
  assign mstart_w = entered && (st_q == StMulP || st_q == StMulI || st_q == StMulD);

  always_comb begin
    dctrl_w.start = dstart_w;
    dctrl_w.is_signed_neg = dneg;
  end

  always_comb begin
    dt_s   = {1'b0, dt_q};
    err_n  = (mode_q == ModePos)
           ? sat32(64'(signed'(set_q)) - (64'(signed'(cnt_q)) <<< FRAC_BITS))
           : sat32(64'(signed'(set_q)) - 64'(signed'(svel_q)));
    pprod  = 64'(err_n * dt_s);
    if (pprod > IMax) pprod = IMax;
    if (pprod < IMin) pprod = IMin;
    if (pprod > 0 && integ_q > IMax - pprod) isum = IMax;
    else if (pprod < 0 && integ_q < IMin - pprod) isum = IMin;
    else isum = integ_q + pprod;
    sabs = sum_q[127] ? 128'd0 - sum_q : sum_q;
    if ((sabs >> (2 * FRAC_BITS)) > 128'd1023) mag = 64'd1023;
    else mag = 64'(sabs >> (2 * FRAC_BITS));
    upd_eff = mag != 64'd0;
    if (mag > {56'd0, ceil_q}) mag = {56'd0, ceil_q};
    if (mag < {56'd0, floor_q}) mag = {56'd0, floor_q};
    rawq  = sum_q[127] ? -mag : mag;
    eff_n = upd_eff ? rawq[8:0] : 9'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeOff; kp_q <= '0; ki_q <= '0; kd_q <= '0; set_q <= '0;
      floor_q <= '0; ceil_q <= 8'd255; poll_q <= 16'd50;
      spos_q <= '0; svel_q <= '0; vel_q <= '0; acc_q <= '0; perr_q <= '0; stime_q <= '0;
      integ_q <= '0; eff_q <= '0; err_q <= '0; der_q <= '0;
      st_q <= StIdle; st_prev_q <= StIdle;
      m_axis_tvalid <= 1'b0; smp_q <= 1'b0;
    end else begin
      st_q <= st_d;
      st_prev_q <= st_q;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (reg_idx_e'(cfg_index_i))
          RegMode:  mode_q  <= mode_e'(cfg_data_i[1:0]);
          RegKp:    kp_q    <= cfg_data_i;
          RegKi:    ki_q    <= cfg_data_i;
          RegKd:    kd_q    <= cfg_data_i;
          RegSet:   set_q   <= cfg_data_i;
          RegFloor: floor_q <= cfg_data_i[7:0];
          RegCeil:  ceil_q  <= cfg_data_i[7:0];
          RegPoll:  poll_q  <= cfg_data_i[15:0];
          default: ;
        endcase
        if (pid_clear) begin
          integ_q <= '0;
          perr_q  <= '0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (acc_in) begin
        smp_q <= elapsed >= poll_eff;
        if (elapsed < poll_eff) begin
          m_axis_tvalid <= 1'b1;
          if (!active) eff_q <= '0;
        end
      end
      if (st_q == StAccDiv && !entered && !dbusy) begin
        acc_q   <= sat32(dquo);
        svel_q  <= vel_q;
        spos_q  <= cnt_q;
        stime_q <= now_q;
      end
      if (st_q == StVelDiv && !entered && !dbusy) vel_q <= sat32(dquo);
      if (st_q == StErr) begin
        err_q   <= err_n;
        integ_q <= isum;
      end
      if (st_q == StDerDiv && !entered && !dbusy) begin
        der_q  <= dquo;
        perr_q <= err_q;
      end
      if (st_q == StOut) begin
        m_axis_tvalid <= 1'b1;
        if (!active) eff_q <= '0;
        else eff_q <= eff_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      cnt_q <= s_axis_tdata[31:0];
      now_q <= s_axis_tdata[63:32];
      dt_q  <= elapsed;
    end
    if (st_q == StMulP && entered) sum_q <= '0;
    if ((st_q == StMulI || st_q == StMulD || st_q == StScale) && entered)
      sum_q <= sum_q + mprod;
  end

  // The divider and multiplier take their launch pulses from state entry.
  assign mstart = mstart_w;

  logic [1:0] dir;
  assign dir = (eff_q > 0) ? DirFwd : ((eff_q < 0) ? DirBack : DirStop);
  assign m_axis_tdata = {5'd0, acc_q, svel_q, cnt_q, dir, eff_q};
  assign m_axis_tuser = smp_q;

  `EPML_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, st_q != StIdle, !s_axis_tready)
  `EPML_ASSERT_IMP(a_dir_sign, clk_i, rst_ni, m_axis_tvalid,
    (eff_q == 9'sd0) == (dir == DirStop))
  `EPML_ASSERT_NXT(a_out_after, clk_i, rst_ni, st_q == StOut, m_axis_tvalid)
endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the encoder PID motor loop: directed and random requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import epml_pkg::*;

  typedef struct packed {
    logic [8:0]  effort;
    logic [1:0]  dir;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] acc;
    logic        smp;
  } loop_out_t;

  localparam longint IntegMax = (longint'(1) <<< 47) - 1;
  localparam longint IntegMin = -IntegMax - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  encoder_pid_motor_loop uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Predictor state and configuration.
  mode_e       ctl_mode;
  longint      kp, ki, kd, target;
  int unsigned pwm_lo, pwm_hi, poll_ms;
  longint      last_pos, last_vel, integ_acc, last_err, accel_q, drive;
  logic [31:0] last_time;

  loop_out_t   pending_q[$];
  int          fail_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  logic [31:0] clock_ms = '0;
  logic signed [31:0] enc_pos = '0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [127:0] widen(longint v);
    logic signed [127:0] w;
    w = v;
    return w;
  endfunction

  function automatic loop_out_t loop_step(logic signed [31:0] cnt, logic [31:0] now);
    logic [31:0]         el;
    longint              dt, vel, err, p, deriv, raw;
    logic signed [127:0] s_sum, mag_w;
    bit                  act, smp;
    loop_out_t           r;
    el  = now - last_time;
    act = (ctl_mode == ModePos) || (ctl_mode == ModeVel);
    smp = el >= ((poll_ms == 0) ? 32'd1 : poll_ms);
    if (smp) begin
      dt = longint'({32'b0, el});
      vel = sat32(((longint'(cnt) - last_pos) * 65536) / dt);
      accel_q = sat32((vel - last_vel) / dt);
      last_pos = cnt;
      last_vel = vel;
      if (act) begin
        if (ctl_mode == ModePos) err = sat32(target - longint'(cnt) * 65536);
        else err = sat32(target - vel);
        s_sum = widen(err) * widen(dt);
        if (s_sum > widen(IntegMax)) p = IntegMax;
        else if (s_sum < widen(IntegMin)) p = IntegMin;
        else p = longint'(s_sum);
        integ_acc = integ_acc + p;
        if (integ_acc > IntegMax) integ_acc = IntegMax;
        if (integ_acc < IntegMin) integ_acc = IntegMin;
        deriv = (err - last_err) / dt;
        last_err = err;
        s_sum = widen(kp) * widen(err) + widen(ki) * widen(integ_acc)
              + widen(kd) * widen(deriv);
        mag_w = (s_sum < 0) ? -s_sum : s_sum;
        mag_w = mag_w >>> 32;
        raw = (mag_w > 1023) ? 1023 : longint'(mag_w);
        if (raw == 0) drive = 0;
        else begin
          if (raw > pwm_hi) raw = pwm_hi;
          if (raw < pwm_lo) raw = pwm_lo;
          drive = (s_sum < 0) ? -raw : raw;
        end
      end
      last_time = now;
    end
    if (!act) drive = 0;
    r.effort = drive[8:0];
    r.dir    = (drive > 0) ? DirFwd : ((drive < 0) ? DirBack : DirStop);
    r.pos    = cnt;
    r.vel    = last_vel[31:0];
    r.acc    = accel_q[31:0];
    r.smp    = smp;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

  always @(posedge clk_i) begin
    loop_out_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.effort = m_axis_tdata[8:0];
      got.dir    = m_axis_tdata[10:9];
      got.pos    = m_axis_tdata[42:11];
      got.vel    = m_axis_tdata[74:43];
      got.acc    = m_axis_tdata[106:75];
      got.smp    = m_axis_tuser;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", got.pos, '0);
      end else begin
        want = pending_q.pop_front();
        if (got.effort !== want.effort)
          report_mismatch("effort", 32'(got.effort), 32'(want.effort));
        if (got.dir !== want.dir) report_mismatch("direction", 32'(got.dir), 32'(want.dir));
        if (got.pos !== want.pos) report_mismatch("position", got.pos, want.pos);
        if (got.vel !== want.vel) report_mismatch("velocity", got.vel, want.vel);
        if (got.acc !== want.acc) report_mismatch("accel", got.acc, want.acc);
        if (got.smp !== want.smp) report_mismatch("sampled", 32'(got.smp), 32'(want.smp));
      end
    end
  end

  task automatic send_request(logic signed [31:0] cnt, logic [31:0] now);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {now, cnt};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(loop_step(cnt, now));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    drain();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegMode:  ctl_mode = mode_e'(val[1:0]);
      RegKp:    kp = longint'($signed(val));
      RegKi:    ki = longint'($signed(val));
      RegKd:    kd = longint'($signed(val));
      RegSet:   target = longint'($signed(val));
      RegFloor: pwm_lo = val[7:0];
      RegCeil:  pwm_hi = val[7:0];
      RegPoll:  poll_ms = val[15:0];
      default: ;
    endcase
    if (idx <= RegSet) begin
      integ_acc = 0;
      last_err = 0;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h1fffff) - 32'h100000;
    endcase
  endfunction

  task automatic test_directed();
    send_request(32'sd0, 32'd0);
    send_request(32'sd100, 32'd49);
    send_request(32'sd200, 32'd50);
    send_request(32'h7fffffff, 32'd51);
    send_request(32'h80000000, 32'hffffffff);
    write_reg(RegMode, ModePos);
    write_reg(RegKp, 32'h00010000);
    write_reg(RegKi, 32'h00000100);
    write_reg(RegKd, 32'h00020000);
    write_reg(RegSet, 32'h00640000);
    write_reg(RegPoll, 32'd0);
    send_request(32'sd10, 32'd0);
    send_request(32'sd20, 32'd1);
    send_request(32'sd300, 32'd2);
    write_reg(RegFloor, 8'd200);
    write_reg(RegCeil, 8'd40);
    send_request(32'sd150, 32'd3);
    send_request(32'sd50, 32'd4);
    write_reg(RegFloor, 8'd0);
    write_reg(RegCeil, 8'd0);
    send_request(32'sd0, 32'd5);
    write_reg(RegCeil, 8'd255);
    write_reg(RegMode, ModeVel);
    write_reg(RegSet, 32'h80000000);
    send_request(32'h7fffffff, 32'd6);
    send_request(32'h80000000, 32'h80000006);
    write_reg(RegMode, ModeRsv);
    send_request(32'sd5, 32'h80000010);
    write_reg(RegPoll, 32'd65535);
    send_request(32'sd6, 32'h80000020);
    send_request(32'sd7, 32'h8001001f);
    clock_ms = 32'h8001001f;
    enc_pos  = 32'sd7;
  endtask

  task automatic randomize_setup();
    write_reg(RegMode, $urandom_range(0, 9) < 8 ? $urandom_range(1, 2) : $urandom);
    write_reg(RegKp, pick_gain());
    write_reg(RegKi, pick_gain());
    write_reg(RegKd, pick_gain());
    write_reg(RegSet, $urandom_range(0, 3) == 0 ? $urandom
                      : $urandom_range(0, 32'h3ffffff) - 32'h2000000);
    write_reg(RegFloor, $urandom_range(0, 3) == 0 ? 32'd255 : $urandom_range(0, 60));
    write_reg(RegCeil, $urandom_range(0, 3) == 0 ? $urandom : 32'd255);
    write_reg(RegPoll, $urandom_range(0, 9) == 0 ? 32'd65535
                       : ($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 20)));
  endtask

  task automatic test_random(int unsigned src_pct, int unsigned snk_pct, int n_items);
    int unsigned poll;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) randomize_setup();
      if (i % 100 == 50) drain();
      poll = (poll_ms == 0) ? 1 : poll_ms;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: clock_ms = clock_ms + poll + $urandom_range(0, 3);
        6, 7: clock_ms = clock_ms + $urandom_range(0, poll);
        8: clock_ms = $urandom;
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) enc_pos = $urandom;
      else enc_pos = enc_pos + $signed($urandom_range(0, 400)) - 200;
      send_request(enc_pos, clock_ms);
    end
  endtask

  initial begin
    ctl_mode = ModeOff; kp = 0; ki = 0; kd = 0; target = 0;
    pwm_lo = 0; pwm_hi = 255; poll_ms = 50;
    last_pos = 0; last_vel = 0; integ_acc = 0; last_err = 0; accel_q = 0; drive = 0;
    last_time = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(6, 52, 640);
    test_random(52, 6, 640);
    test_random(0, 0, 640);
    drain();
    repeat (400) @(negedge clk_i);
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/epml_pkg.sv
hdl/epml_div.sv
hdl/epml_mul.sv
hdl/encoder_pid_motor_loop.sv
sim/tb_top.sv
